[hw/rtl/smpte337_burst_deframer_top_macros.svh]
// assertion macros shared by the deframer modules
// clocked on clk, disabled while arst_n is low
`ifndef SMPTE337_BURST_DEFRAMER_TOP_MACROS_SVH
`define SMPTE337_BURST_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define S337D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define S337D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/s337d_pkg.sv]
// ----------------------------------------------------------------------------
// s337d_pkg
// Shared constants and result type of the SMPTE 337 burst deframer.
// ----------------------------------------------------------------------------
package s337d_pkg;

	localparam logic [31:0] SYNC20_A = {20'h6f872, 12'h000};
	localparam logic [31:0] SYNC20_B = {20'h54e1f, 12'h000};
	localparam logic [31:0] SYNC24_A = {24'h96f872, 8'h00};
	localparam logic [31:0] SYNC24_B = {24'ha54e1f, 8'h00};

	localparam logic [15:0] MAX_FRAME_RESET = 16'd4000;

	typedef logic signed [31:0] sample_t;

	typedef struct packed {
		logic signed [31:0] out_left;
		logic signed [31:0] out_right;
		logic               in_frame;
		logic               frame_start;
		logic               frame_end;
		logic [4:0]         burst_type;
		logic               burst_error;
		logic               is_24bit;
		logic [23:0]        payload_length;
		logic [15:0]        frame_pairs;
		logic               overflow;
	} res_t;

endpackage

[hw/rtl/s337d_core.sv]
// ----------------------------------------------------------------------------
// s337d_core
// Sync hunt, frame state and result build for one sample pair word.
// ----------------------------------------------------------------------------
module s337d_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  s337d_pkg::sample_t left_sample,
	input  s337d_pkg::sample_t right_sample,
	input  logic [15:0]       max_frame_pairs,
	output s337d_pkg::res_t   res
);
	import s337d_pkg::*;
	`include "smpte337_burst_deframer_top_macros.svh"

	logic        locked_q;
	logic        held_valid_q;
	logic        held_is_sync_q;
	logic        width_mode_q;
	logic [15:0] pair_count_q;
	logic [31:0] held_left_q;
	logic [31:0] held_right_q;
	logic [15:0] pc_word_q;
	logic [23:0] pd_word_q;

	logic s20, s24, cur_sync;
	logic in_frame, ovf, fend;

	assign s20      = (left_sample == SYNC20_A) && (right_sample == SYNC20_B);
	assign s24      = (left_sample == SYNC24_A) && (right_sample == SYNC24_B);
	assign cur_sync = s20 || s24;

	assign in_frame = held_valid_q && locked_q;
	assign ovf      = in_frame && !cur_sync && (pair_count_q >= max_frame_pairs);
	assign fend     = in_frame && (cur_sync || ovf);

	always_comb begin
		res.out_left       = held_valid_q ? held_left_q : '0;
		res.out_right      = held_valid_q ? held_right_q : '0;
		res.in_frame       = in_frame;
		res.frame_start    = in_frame && held_is_sync_q;
		res.frame_end      = fend;
		res.burst_type     = fend ? pc_word_q[4:0] : 5'd0;
		res.burst_error    = fend ? pc_word_q[7] : 1'b0;
		res.is_24bit       = in_frame && width_mode_q;
		res.payload_length = fend ? pd_word_q : 24'd0;
		res.frame_pairs    = fend ? pair_count_q : 16'd0;
		res.overflow       = ovf;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q       <= 1'b0;
			held_valid_q   <= 1'b0;
			held_is_sync_q <= 1'b0;
			width_mode_q   <= 1'b0;
			pair_count_q   <= '0;
		end else if (accept) begin
			held_valid_q <= 1'b1;
			if (cur_sync) begin
				locked_q       <= 1'b1;
				held_is_sync_q <= 1'b1;
				width_mode_q   <= s24;
				pair_count_q   <= 16'd1;
			end else begin
				held_is_sync_q <= 1'b0;
				if (in_frame && !ovf) begin
					pair_count_q <= pair_count_q + 16'd1;
				end else begin
					locked_q     <= 1'b0;
					pair_count_q <= '0;
				end
			end
		end
	end

	// payload state
	always_ff @(posedge clk) begin
		if (accept) begin
			held_left_q  <= left_sample;
			held_right_q <= right_sample;
			if (cur_sync) begin
				pc_word_q <= '0;
				pd_word_q <= '0;
			end else if (in_frame && !ovf && pair_count_q == 16'd1) begin
				pc_word_q <= left_sample[31:16];
				pd_word_q <= width_mode_q ? right_sample[31:8]
				                          : {4'd0, right_sample[31:12]};
			end
		end
	end

	`S337D_ASSERT_NOW(a_end_in_frame, res.frame_end, res.in_frame, "frame end outside frame")
	`S337D_ASSERT_NOW(a_ovf_is_end, res.overflow, res.frame_end && !cur_sync, "overflow without end")
	`S337D_ASSERT_NEXT(a_sync_locks, accept && cur_sync,
		locked_q && held_is_sync_q && pair_count_q == 16'd1, "sync did not lock")

endmodule

[hw/rtl/smpte337_burst_deframer_top.sv]
// ----------------------------------------------------------------------------
// smpte337_burst_deframer_top
// SMPTE 337 non-PCM burst deframer over stereo sample pair words.
// ----------------------------------------------------------------------------
// Takes one sample pair word per clock. The result for a pair leaves with
// the acceptance of the pair that follows it (one word of delay inside the
// block) and is then held in the output register; a new word is taken
// every cycle unless that register is full and stalled. Frame end, Pc, Pd
// and overflow are reported on the last pair of each frame.
module smpte337_burst_deframer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  s337d_pkg::sample_t left_sample,
	input  s337d_pkg::sample_t right_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output s337d_pkg::sample_t out_left,
	output s337d_pkg::sample_t out_right,
	output logic               in_frame,
	output logic               frame_start,
	output logic               frame_end,
	output logic [4:0]         burst_type,
	output logic               burst_error,
	output logic               is_24bit,
	output logic [23:0]        payload_length,
	output logic [15:0]        frame_pairs,
	output logic               overflow
);
	import s337d_pkg::*;
	`include "smpte337_burst_deframer_top_macros.svh"

	logic [15:0] max_frame_q;
	logic        out_valid_q;
	logic        in_accept;
	res_t        res;
	res_t        res_q;

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
		end else if (cfg_we) begin
			max_frame_q <= cfg_wdata;
		end
	end

	s337d_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (in_accept),
		.left_sample     (left_sample),
		.right_sample    (right_sample),
		.max_frame_pairs (max_frame_q),
		.res             (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_left       = res_q.out_left;
	assign out_right      = res_q.out_right;
	assign in_frame       = res_q.in_frame;
	assign frame_start    = res_q.frame_start;
	assign frame_end      = res_q.frame_end;
	assign burst_type     = res_q.burst_type;
	assign burst_error    = res_q.burst_error;
	assign is_24bit       = res_q.is_24bit;
	assign payload_length = res_q.payload_length;
	assign frame_pairs    = res_q.frame_pairs;
	assign overflow       = res_q.overflow;

	`S337D_ASSERT_NOW(a_stall_needs_word, in_stall, out_valid_q, "stall with empty output")
	`S337D_ASSERT_NEXT(a_accept_fills, in_accept, out_valid_q, "accepted word not presented")
	`S337D_ASSERT_NEXT(a_cfg_write, cfg_we, max_frame_q == $past(cfg_wdata), "config write lost")

endmodule
